/* sv/jets_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package jets_pkg;

    // Default number of squarings per iteration (z^8 for three)
    localparam int SQUARINGS_DEF = 3;

    localparam int COORD_W = 32;
    localparam int COUNT_W = 12;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * COORD_W;

    // Escape when |z|^2 > 12.0, as unsigned Q8.56
    localparam logic [PROD_W-1:0] ESC_THRESH = 64'h0C00_0000_0000_0000;

    // 4.0 in the Q8.40 scale of the truncated magnitude
    localparam logic [47:0] DIV_OFFSET = 48'h0400_0000_0000;

    // One quotient bit per divider cycle
    localparam int DIV_STEPS = FRAC_W;

    localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_C_REAL = 2'd0,
        REG_C_IMAG = 2'd1,
        REG_LEVELS = 2'd2,
        REG_SMOOTH = 2'd3
    } cfg_reg_e_t;

    // Sequencer states of the iteration core
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MUL_XY,
        ST_SQ_UPD,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } state_t;

    // Settings seen by the core
    typedef struct packed {
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
        logic [COUNT_W-1:0]        limit;
        logic                      smooth;
    } core_cfg_t;

    // One result
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [FRAC_W-1:0]  frac;
    } result_t;

endpackage

`default_nettype wire

/* sv/jets_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module jets_core import jets_pkg::*; #(
    parameter int SQUARINGS = SQUARINGS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire core_cfg_t                 cfg,
    input  wire logic                      start_valid,
    output logic                           start_ready,
    input  wire logic signed [COORD_W-1:0] start_real,
    input  wire logic signed [COORD_W-1:0] start_imag,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output result_t                        res
);

    localparam int SQ_W  = (SQUARINGS > 1) ? $clog2(SQUARINGS) : 1;
    localparam int DIV_W = $clog2(DIV_STEPS);

    // Saturate a wide signed value to 32 bits; top bit flags overflow
    function automatic logic [COORD_W:0] sat_wide(input logic signed [PROD_W-1:0] v);
        logic ovf;
        logic [COORD_W-1:0] val;
        ovf = !((&v[PROD_W-1:COORD_W-1]) || !(|v[PROD_W-1:COORD_W-1]));
        val = ovf ? (v[PROD_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : v[COORD_W-1:0];
        return {ovf, val};
    endfunction

    // Saturate a 33-bit sum to 32 bits; top bit flags overflow
    function automatic logic [COORD_W:0] sat_sum(input logic [COORD_W:0] v);
        logic ovf;
        logic [COORD_W-1:0] val;
        ovf = v[COORD_W] != v[COORD_W-1];
        val = ovf ? (v[COORD_W] ? 32'h8000_0000 : 32'h7FFF_FFFF) : v[COORD_W-1:0];
        return {ovf, val};
    endfunction

    state_t                      state_reg, state_next;
    logic signed [COORD_W-1:0]   x_reg, x_next;
    logic signed [COORD_W-1:0]   y_reg, y_next;
    logic signed [PROD_W-1:0]    p_reg;
    logic signed [PROD_W-1:0]    xx_reg, xx_next;
    logic signed [PROD_W-1:0]    yy_reg, yy_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic [FRAC_W-1:0]           frac_reg, frac_next;
    logic [SQ_W-1:0]             sq_reg, sq_next;
    logic                        check_reg, check_next;
    logic                        sat_reg, sat_next;
    logic [48:0]                 rem_reg, rem_next;
    logic [47:0]                 d_reg, d_next;
    logic [DIV_W-1:0]            div_cnt_reg, div_cnt_next;

    logic signed [COORD_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]    product;
    logic [PROD_W-1:0]           mag;
    logic                        escaped;
    logic signed [PROD_W-1:0]    diff;
    logic [COORD_W:0]            re_sat, im_sat, xr_sat, yi_sat;
    logic [48:0]                 div_sh;
    logic                        div_ge;
    logic [COUNT_W-1:0]          count_inc;

    // Shared multiplier: operand select by sequencer state
    assign mul_a   = (state_reg == ST_MUL_YY) ? y_reg : x_reg;
    assign mul_b   = (state_reg == ST_MUL_XX) ? x_reg : y_reg;
    assign product = mul_a * mul_b;

    // Escape test: xx in xx_reg, yy arriving in p_reg
    assign mag     = unsigned'(xx_reg) + unsigned'(p_reg);
    assign escaped = mag > ESC_THRESH;

    // Squaring update: re = (xx - yy) >> 28, im = xy >> 27
    assign diff    = xx_reg - yy_reg;
    assign re_sat  = sat_wide(diff >>> 28);
    assign im_sat  = sat_wide(p_reg >>> 27);

    // Add c
    assign xr_sat  = sat_sum({x_reg[COORD_W-1], x_reg} + {cfg.c_real[COORD_W-1], cfg.c_real});
    assign yi_sat  = sat_sum({y_reg[COORD_W-1], y_reg} + {cfg.c_imag[COORD_W-1], cfg.c_imag});

    // Restoring divider step
    assign div_sh  = {rem_reg[47:0], 1'b0};
    assign div_ge  = div_sh >= {1'b0, d_reg};

    assign count_inc = count_reg + COUNT_W'(1);

    assign start_ready = state_reg == ST_IDLE;
    assign res_valid   = state_reg == ST_DONE;
    assign res.count   = count_reg;
    assign res.frac    = frac_reg;

    // State register and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        p_reg       <= product;
        x_reg       <= x_next;
        y_reg       <= y_next;
        xx_reg      <= xx_next;
        yy_reg      <= yy_next;
        count_reg   <= count_next;
        frac_reg    <= frac_next;
        sq_reg      <= sq_next;
        check_reg   <= check_next;
        sat_reg     <= sat_next;
        rem_reg     <= rem_next;
        d_reg       <= d_next;
        div_cnt_reg <= div_cnt_next;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        xx_next      = xx_reg;
        yy_next      = yy_reg;
        count_next   = count_reg;
        frac_next    = frac_reg;
        sq_next      = sq_reg;
        check_next   = check_reg;
        sat_next     = sat_reg;
        rem_next     = rem_reg;
        d_next       = d_reg;
        div_cnt_next = div_cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start_valid) begin
                    x_next     = start_real;
                    y_next     = start_imag;
                    count_next = '0;
                    frac_next  = '0;
                    sq_next    = '0;
                    check_next = 1'b0;
                    sat_next   = 1'b0;
                    state_next = (cfg.limit == '0) ? ST_DONE : ST_MUL_XX;
                end
            end
            ST_MUL_XX: begin
                state_next = ST_MUL_YY;
            end
            ST_MUL_YY: begin
                xx_next    = p_reg;
                state_next = ST_MUL_XY;
            end
            ST_MUL_XY: begin
                yy_next    = p_reg;
                state_next = ST_SQ_UPD;
                // End of an iteration: test magnitude of z + c
                if (check_reg) begin
                    check_next = 1'b0;
                    if (escaped) begin
                        if (cfg.smooth) begin
                            rem_next     = {1'b0, mag[63:16]};
                            d_next       = mag[63:16] + DIV_OFFSET;
                            div_cnt_next = '0;
                            state_next   = ST_DIV;
                        end else begin
                            frac_next  = '0;
                            state_next = ST_DONE;
                        end
                    end else begin
                        count_next = count_inc;
                        if (count_inc == cfg.limit) begin
                            frac_next  = '0;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_SQ_UPD: begin
                x_next = re_sat[COORD_W-1:0];
                y_next = im_sat[COORD_W-1:0];
                if (re_sat[COORD_W] || im_sat[COORD_W]) begin
                    sat_next = 1'b1;
                end
                if (sq_reg == SQ_W'(SQUARINGS - 1)) begin
                    sq_next    = '0;
                    state_next = ST_ADD;
                end else begin
                    sq_next    = sq_reg + SQ_W'(1);
                    state_next = ST_MUL_XX;
                end
            end
            ST_ADD: begin
                x_next = xr_sat[COORD_W-1:0];
                y_next = yi_sat[COORD_W-1:0];
                // sat_reg carries saturation from the squarings
                if (sat_reg || xr_sat[COORD_W] || yi_sat[COORD_W]) begin
                    frac_next  = cfg.smooth ? FRAC_MAX : '0;
                    state_next = ST_DONE;
                end else begin
                    check_next = 1'b1;
                    state_next = ST_MUL_XX;
                end
            end
            ST_DIV: begin
                rem_next  = div_ge ? (div_sh - {1'b0, d_reg}) : div_sh;
                frac_next = {frac_reg[FRAC_W-2:0], div_ge};
                if (div_cnt_reg == DIV_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    div_cnt_next = div_cnt_reg + DIV_W'(1);
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // While iterating, the count stays below the limit
    a_count_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_DONE && state_reg != ST_DIV)
            |-> (count_reg < cfg.limit))
        else $error("iteration count reached limit while busy");

    // Divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, d_reg}))
        else $error("divider remainder out of range");

    // Plain mode never reports a fraction
    a_plain_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !cfg.smooth) |-> (frac_reg == '0))
        else $error("nonzero fraction in plain mode");

    // Squaring counter stays in range during an iteration
    a_sq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQ_UPD) |-> (sq_reg <= SQ_W'(SQUARINGS - 1)))
        else $error("squaring counter out of range");

    // A result is held until taken
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("result dropped before it was taken");

endmodule

`default_nettype wire

/* sv/julia_escape_time_smooth_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    s_tdata: point_real, point_imag
// m_        out  m_tvalid / m_tready    m_tdata: escape_count, escape_fraction
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One shared 32x32 multiplier does every product. Each iteration runs
// ST_MUL_XX, ST_MUL_YY, ST_MUL_XY and ST_SQ_UPD once per squaring, then
// ST_ADD adds c; the magnitude of z + c is tested on the next multiplies,
// and in smooth mode a bit-serial divider forms the escape fraction.
// Reset is synchronous on aresetn; the input is not ready while a point is
// being iterated. A finished result sits in the output register, and a new
// point may be taken while it waits for m_tready.

module julia_escape_time_smooth_top import jets_pkg::*; #(
    parameter int SQUARINGS = SQUARINGS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // [31:0] point_real, [63:32] point_imag
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [11:0] escape_count, [27:12] escape_fraction, [31:28] zero
    output logic [31:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic signed [COORD_W-1:0] c_real_reg;
    logic signed [COORD_W-1:0] c_imag_reg;
    logic [COUNT_W-1:0]        levels_reg;
    logic                      smooth_reg;

    logic                      m_valid_reg, m_valid_next;
    result_t                   m_res_reg;

    core_cfg_t                 core_cfg;
    logic [COUNT_W-1:0]        drop;
    logic                      core_res_valid;
    logic                      core_res_ready;
    result_t                   core_res;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_real_reg <= '0;
            c_imag_reg <= '0;
            levels_reg <= COUNT_W'(300);
            smooth_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_C_REAL: c_real_reg <= cfg_data;
                REG_C_IMAG: c_imag_reg <= cfg_data;
                REG_LEVELS: levels_reg <= cfg_data[COUNT_W-1:0];
                REG_SMOOTH: smooth_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Iteration limit: levels minus two (smooth) or one (plain), floored at zero
    assign drop            = smooth_reg ? COUNT_W'(2) : COUNT_W'(1);
    assign core_cfg.c_real = c_real_reg;
    assign core_cfg.c_imag = c_imag_reg;
    assign core_cfg.smooth = smooth_reg;
    assign core_cfg.limit  = (levels_reg > drop) ? (levels_reg - drop) : '0;

    jets_core #(
        .SQUARINGS (SQUARINGS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (core_cfg),
        .start_valid (s_tvalid),
        .start_ready (s_tready),
        .start_real  (s_tdata[31:0]),
        .start_imag  (s_tdata[63:32]),
        .res_valid   (core_res_valid),
        .res_ready   (core_res_ready),
        .res         (core_res)
    );

    // Output register
    assign core_res_ready = !m_valid_reg || m_tready;
    assign m_valid_next   = (core_res_valid && core_res_ready) || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_res_valid && core_res_ready) begin
            m_res_reg <= core_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_res_reg.frac, m_res_reg.count};

endmodule

`default_nettype wire
